// ===== src/dga_pkg.sv =====
package dga_pkg;

    // Default table depth
    localparam int MaxPlayersDef = 64;

    // Field widths
    localparam int IdW   = 7;
    localparam int PosW  = 24;
    localparam int TimeW = 32;
    localparam int DistW = 24;
    localparam int GainW = 16;
    localparam int SmW   = 17;
    localparam int OcW   = 2;

    // Packed position and time entry: {time, z, y, x}
    localparam int PtW = 3 * PosW + TimeW;
    // Known flag plus smoothed gain
    localparam int KsW = SmW + 1;

    // Fixed-point constants
    localparam logic [SmW-1:0]   UnityQ16 = 17'd65536;
    localparam logic [GainW-1:0] UnityQ12 = 16'd4096;
    localparam logic [TimeW-1:0] StaleMs  = 32'd5000;
    localparam logic [DistW:0]   OneMetre = 25'd256;

    // Outcome codes
    localparam logic [OcW-1:0] OC_COMPUTED = 2'd0;
    localparam logic [OcW-1:0] OC_UNKNOWN  = 2'd1;
    localparam logic [OcW-1:0] OC_STALE    = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_LOCAL  = 3'd0;
    localparam logic [2:0] REG_NEAR   = 3'd1;
    localparam logic [2:0] REG_FAR    = 3'd2;
    localparam logic [2:0] REG_SMOOTH = 3'd3;
    localparam logic [2:0] REG_OGAIN  = 3'd4;

endpackage

// ===== src/dga_ram.sv =====
module dga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/distance_gain_attenuator_unit.sv =====
// Distance gain attenuator: per-player position table and smoothed gain table.
// Position update: no result; the entry is written on acceptance and the known flag in ST_UWR.
// Query: a bad id goes straight to the result, an unknown or stale player after the table read,
// a computed gain through squares, a 25-step root, a 16-step falloff divide when needed, smoothing and output gain.
// One item is in work at a time. Reset: control registers take their defaults, then a clearing
// pass over all MAX_PLAYERS entries zeroes the known flags and smoothed gains.
module distance_gain_attenuator_unit #(
    parameter int MAX_PLAYERS = dga_pkg::MaxPlayersDef
) (
    input  logic          clk,
    input  logic          rst_n,
    // fields: pid[6:0], pos_x[30:7], pos_y[54:31], pos_z[78:55], now_ms[110:79]
    input  logic [111:0]  s_tdata,
    // fields: mode[0]
    input  logic          s_tuser,
    input  logic          s_tvalid,
    output logic          s_tready,
    // fields: gain[15:0]
    output logic [15:0]   m_tdata,
    // fields: outcome[1:0]
    output logic [1:0]    m_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);

    import dga_pkg::*;

    localparam int IDX_W = $clog2(MAX_PLAYERS);

    // Sequencer states
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_UWR  = 4'd2;
    localparam logic [3:0] ST_QL   = 4'd3;
    localparam logic [3:0] ST_QR   = 4'd4;
    localparam logic [3:0] ST_SQ   = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_TGT  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_SM1  = 4'd9;
    localparam logic [3:0] ST_SM2  = 4'd10;
    localparam logic [3:0] ST_SM3  = 4'd11;
    localparam logic [3:0] ST_OG   = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    // Input fields
    logic [IdW-1:0]   in_pid;
    logic [PosW-1:0]  in_x, in_y, in_z;
    logic [TimeW-1:0] in_now;
    logic             accept, in_ok, loc_ok;

    // Control registers
    logic [3:0]       state_reg, state_next;
    logic [4:0]       cnt_reg;
    logic [IDX_W-1:0] clr_reg;
    logic             out_valid_reg;
    logic [GainW-1:0] out_gain_reg;
    logic [OcW-1:0]   out_oc_reg;
    logic [IdW-1:0]   local_reg;
    logic [DistW-1:0] near_reg, far_reg;
    logic [SmW-1:0]   smooth_reg;
    logic [GainW-1:0] ogain_reg;

    // Datapath registers
    logic [IDX_W-1:0]        rid_reg;
    logic [TimeW-1:0]        now_reg;
    logic signed [PosW-1:0]  lx_reg, ly_reg, lz_reg;
    logic                    lknown_reg;
    logic signed [PosW:0]    dx_reg, dy_reg, dz_reg;
    logic [SmW-1:0]          sold_reg, tgt_reg, snew_reg;
    logic [49:0]             prod_reg, sum_reg;
    logic [24:0]             root_reg, den_reg;
    logic [25:0]             rem_reg;
    logic [DistW:0]          fe_reg;
    logic [33:0]             acc_reg;
    logic [GainW-1:0]        res_gain_reg;
    logic [OcW-1:0]          res_oc_reg;

    // Memory ports
    logic             pt_we, pt_re, ks_we, ks_re;
    logic [IDX_W-1:0] pt_waddr, pt_raddr, ks_waddr, ks_raddr;
    logic [PtW-1:0]   pt_wdata, pt_rdata;
    logic [KsW-1:0]   ks_wdata, ks_rdata;

    // Misc combinational
    logic [IDX_W-1:0]       pidx, lidx;
    logic signed [PosW-1:0] r_x, r_y, r_z;
    logic [TimeW-1:0]       r_time, age;
    logic signed [PosW:0]   sq_sel;
    logic [27:0]            rem_sh, trial;
    logic [25:0]            div_sh;
    logic [SmW-1:0]         alpha;
    logic [34:0]            sm_sum;
    logic [33:0]            og_sum;

    assign in_pid = s_tdata[6:0];
    assign in_x   = s_tdata[30:7];
    assign in_y   = s_tdata[54:31];
    assign in_z   = s_tdata[78:55];
    assign in_now = s_tdata[110:79];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_ok  = !in_pid[6] && ({26'd0, in_pid[5:0]} < 32'(MAX_PLAYERS));
    assign loc_ok = !local_reg[6] && ({26'd0, local_reg[5:0]} < 32'(MAX_PLAYERS));
    assign pidx   = IDX_W'(in_pid[5:0]);
    assign lidx   = IDX_W'(local_reg[5:0]);

    assign r_x    = pt_rdata[PosW-1:0];
    assign r_y    = pt_rdata[2*PosW-1:PosW];
    assign r_z    = pt_rdata[3*PosW-1:2*PosW];
    assign r_time = pt_rdata[PtW-1:3*PosW];
    assign age    = now_reg - r_time;

    assign alpha = (smooth_reg > UnityQ16) ? UnityQ16 : smooth_reg;

    assign m_tdata  = out_gain_reg;
    assign m_tuser  = out_oc_reg;
    assign m_tvalid = out_valid_reg;

    dga_ram #(.WIDTH(PtW), .DEPTH(MAX_PLAYERS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    dga_ram #(.WIDTH(KsW), .DEPTH(MAX_PLAYERS)) u_ks_ram (
        .clk   (clk),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (ks_wdata),
        .re    (ks_re),
        .raddr (ks_raddr),
        .rdata (ks_rdata)
    );

    // Memory access steering
    always_comb
    begin
        pt_we    = accept && !s_tuser && in_ok;
        pt_waddr = pidx;
        pt_wdata = {in_now, in_z, in_y, in_x};
        pt_re    = 1'b0;
        pt_raddr = lidx;
        ks_we    = 1'b0;
        ks_waddr = rid_reg;
        ks_wdata = {1'b1, ks_rdata[SmW-1:0]};
        ks_re    = 1'b0;
        ks_raddr = lidx;
        case (state_reg)
            ST_CLR:
            begin
                ks_we    = 1'b1;
                ks_waddr = clr_reg;
                ks_wdata = '0;
            end
            ST_IDLE:
            begin
                if (accept && in_ok)
                begin
                    ks_re = 1'b1;
                    pt_re = s_tuser;
                    if (!s_tuser)
                    begin
                        ks_raddr = pidx;
                    end
                end
            end
            ST_UWR:
            begin
                ks_we = 1'b1;
            end
            ST_QL:
            begin
                pt_re    = 1'b1;
                pt_raddr = rid_reg;
                ks_re    = 1'b1;
                ks_raddr = rid_reg;
            end
            ST_SM3:
            begin
                ks_we    = 1'b1;
                ks_wdata = {1'b1, sm_sum[32:16]};
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                if (clr_reg == IDX_W'(MAX_PLAYERS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        state_next = in_ok ? ST_UWR : ST_IDLE;
                    end
                    else
                    begin
                        state_next = (in_ok && loc_ok) ? ST_QL : ST_FIN;
                    end
                end
            end
            ST_UWR:  state_next = ST_IDLE;
            ST_QL:   state_next = ST_QR;
            ST_QR:
            begin
                if (!lknown_reg || !ks_rdata[SmW] || age >= StaleMs)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = (cnt_reg == 5'd3) ? ST_SQRT : ST_SQ;
            ST_SQRT: state_next = (cnt_reg == 5'd24) ? ST_TGT : ST_SQRT;
            ST_TGT:
            begin
                if ({1'b0, root_reg} >= {1'b0, fe_reg} || root_reg <= {1'b0, near_reg})
                begin
                    state_next = ST_SM1;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = (cnt_reg == 5'd15) ? ST_SM1 : ST_DIV;
            ST_SM1:  state_next = ST_SM2;
            ST_SM2:  state_next = ST_SM3;
            ST_SM3:  state_next = ST_OG;
            ST_OG:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers, configuration and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            local_reg     <= 7'h7F;
            near_reg      <= 24'd1280;
            far_reg       <= 24'd12800;
            smooth_reg    <= 17'd13107;
            ogain_reg     <= UnityQ12;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FIN && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOCAL:  local_reg  <= cfg_data[IdW-1:0];
                    REG_NEAR:   near_reg   <= cfg_data;
                    REG_FAR:    far_reg    <= cfg_data;
                    REG_SMOOTH: smooth_reg <= cfg_data[SmW-1:0];
                    REG_OGAIN:  ogain_reg  <= cfg_data[GainW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath step values
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_sel = dx_reg;
            2'd1:    sq_sel = dy_reg;
            default: sq_sel = dz_reg;
        endcase
        rem_sh = {rem_reg, sum_reg[49:48]};
        trial  = {1'b0, root_reg, 2'b01};
        div_sh = {rem_reg[24:0], 1'b0};
        sm_sum = {1'b0, acc_reg} + {1'b0, prod_reg[33:0]} + 35'd32768;
        og_sum = prod_reg[33:0] + 34'd32768;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rid_reg      <= pidx;
                now_reg      <= in_now;
                res_gain_reg <= UnityQ12;
                res_oc_reg   <= OC_UNKNOWN;
            end
            ST_QL:
            begin
                lx_reg     <= r_x;
                ly_reg     <= r_y;
                lz_reg     <= r_z;
                lknown_reg <= ks_rdata[SmW];
            end
            ST_QR:
            begin
                dx_reg   <= {lx_reg[PosW-1], lx_reg} - {r_x[PosW-1], r_x};
                dy_reg   <= {ly_reg[PosW-1], ly_reg} - {r_y[PosW-1], r_y};
                dz_reg   <= {lz_reg[PosW-1], lz_reg} - {r_z[PosW-1], r_z};
                sold_reg <= ks_rdata[SmW-1:0];
                sum_reg  <= '0;
                prod_reg <= '0;
                if (lknown_reg && ks_rdata[SmW] && age >= StaleMs)
                begin
                    res_gain_reg <= '0;
                    res_oc_reg   <= OC_STALE;
                end
            end
            ST_SQ:
            begin
                // One square per cycle, registered and accumulated in the next cycle
                prod_reg <= 50'(sq_sel * sq_sel);
                sum_reg  <= sum_reg + prod_reg;
                root_reg <= '0;
                rem_reg  <= '0;
                if ({1'b0, far_reg} < {1'b0, near_reg} + OneMetre)
                begin
                    fe_reg <= {1'b0, near_reg} + OneMetre;
                end
                else
                begin
                    fe_reg <= {1'b0, far_reg};
                end
            end
            ST_SQRT:
            begin
                // One root bit per cycle
                sum_reg <= {sum_reg[47:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 26'(rem_sh - trial);
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[25:0];
                    root_reg <= {root_reg[23:0], 1'b0};
                end
            end
            ST_TGT:
            begin
                rem_reg <= {1'b0, fe_reg - root_reg};
                den_reg <= 25'(fe_reg - {1'b0, near_reg});
                if ({1'b0, root_reg} >= {1'b0, fe_reg})
                begin
                    tgt_reg <= '0;
                end
                else
                begin
                    tgt_reg <= UnityQ16;
                end
                if (root_reg > {1'b0, near_reg})
                begin
                    tgt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                if (div_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= div_sh - {1'b0, den_reg};
                    tgt_reg <= {tgt_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_sh;
                    tgt_reg <= {tgt_reg[15:0], 1'b0};
                end
            end
            ST_SM1:
            begin
                acc_reg <= sold_reg * (UnityQ16 - alpha);
            end
            ST_SM2:
            begin
                prod_reg <= {16'd0, 34'(tgt_reg * alpha)};
            end
            ST_SM3:
            begin
                snew_reg <= sm_sum[32:16];
            end
            ST_OG:
            begin
                prod_reg     <= {17'd0, 33'(snew_reg * ogain_reg)};
                res_oc_reg   <= OC_COMPUTED;
            end
            ST_FIN:
            begin
                // Load the output only once the previous transaction has left
                if (!out_valid_reg || m_tready)
                begin
                    if (res_oc_reg == OC_COMPUTED)
                    begin
                        out_gain_reg <= og_sum[31:16];
                    end
                    else
                    begin
                        out_gain_reg <= res_gain_reg;
                    end
                    out_oc_reg <= res_oc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
